// File: rtl/tpq_pkg.sv
package tpq_pkg;

	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int CANCEL_DEPTH_DEF  = 16;
	localparam int TIME_BITS_DEF     = 32;
	localparam int PRIORITY_BITS_DEF = 8;

	localparam int ID_BITS = 31;
	localparam logic [ID_BITS-1:0] IDENT_MASK = 31'h7FFFFFFF;

	typedef enum logic [1:0] {
		OP_SCHEDULE = 2'd0,
		OP_CANCEL   = 2'd1,
		OP_DISPATCH = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef struct packed {
		logic [ID_BITS-1:0] assigned_id;
		logic               dispatched;
		logic [ID_BITS-1:0] dispatched_id;
		logic [7:0]         dispatched_priority;
		logic               refused_full;
	} result_t;

endpackage

// File: rtl/tpq_front.sv
module tpq_front #(
	parameter int TIME_BITS     = tpq_pkg::TIME_BITS_DEF,
	parameter int PRIORITY_BITS = tpq_pkg::PRIORITY_BITS_DEF,
	parameter int CMD_BITS      = 2 + 2*TIME_BITS + PRIORITY_BITS + tpq_pkg::ID_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_BITS-1:0] in_cmd,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output logic [CMD_BITS-1:0] cmd
);
	logic [CMD_BITS-1:0] slot_q [2];
	logic                rd_q, wr_q;
	logic [1:0]          cnt_q;

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) slot_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (cmd_valid && cmd_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, cmd_valid && cmd_ready};
		end
	end
endmodule

// File: rtl/tpq_engine.sv
module tpq_engine #(
	parameter int QUEUE_DEPTH   = tpq_pkg::QUEUE_DEPTH_DEF,
	parameter int CANCEL_DEPTH  = tpq_pkg::CANCEL_DEPTH_DEF,
	parameter int TIME_BITS     = tpq_pkg::TIME_BITS_DEF,
	parameter int PRIORITY_BITS = tpq_pkg::PRIORITY_BITS_DEF,
	parameter int CMD_BITS      = 2 + 2*TIME_BITS + PRIORITY_BITS + tpq_pkg::ID_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  logic [CMD_BITS-1:0] cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output tpq_pkg::result_t    res
);
	localparam int IB = tpq_pkg::ID_BITS;
	localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CA = (CANCEL_DEPTH > 1) ? $clog2(CANCEL_DEPTH) : 1;
	localparam int QC = $clog2(QUEUE_DEPTH + 1);
	localparam int CC = $clog2(CANCEL_DEPTH + 1);

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_DSCAN  = 14'b00000000000010, // due front search
		S_DDEC   = 14'b00000000000100, // act on due front
		S_DREM   = 14'b00000000001000, // due remove (move last)
		S_CSCAN  = 14'b00000000010000, // cancel set search
		S_CDEC   = 14'b00000000100000,
		S_RSCAN  = 14'b00000001000000, // ready front search
		S_RDEC   = 14'b00000010000000,
		S_RREM   = 14'b00000100000000,
		S_OUT    = 14'b00001000000000,
		S_DMOVE  = 14'b00010000000000,
		S_LREAD  = 14'b00100000000000, // read last due entry
		S_RLREAD = 14'b01000000000000,
		S_CREM   = 14'b10000000000000
	} state_t;

	// where a search/removal returns to
	typedef enum logic [2:0] {
		C_CANCEL_FRONT, C_CANCEL_SET, C_DISP_DUE, C_POP_CHECK, C_READY_CHECK
	} ctx_t;

	state_t state_q;
	ctx_t   ctx_q;

	logic [TIME_BITS-1:0]     due_time_q  [QUEUE_DEPTH];
	logic [IB-1:0]            due_ident_q [QUEUE_DEPTH];
	logic [PRIORITY_BITS-1:0] due_prio_q  [QUEUE_DEPTH];
	logic [IB-1:0]            rdy_ident_q [QUEUE_DEPTH];
	logic [PRIORITY_BITS-1:0] rdy_prio_q  [QUEUE_DEPTH];
	logic [IB-1:0]            can_ident_q [CANCEL_DEPTH];
	logic [QC-1:0] due_cnt_q, rdy_cnt_q;
	logic [CC-1:0] can_cnt_q;
	logic [IB-1:0] next_id_q;

	logic [1:0]               op_q;
	logic [TIME_BITS-1:0]     dl_q;
	logic [PRIORITY_BITS-1:0] pv_q;
	logic [IB-1:0]            cid_q;

	logic [QC-1:0]            i_q;
	logic [QA-1:0]            best_q;
	logic [TIME_BITS-1:0]     bt_q;
	logic [IB-1:0]            bid_q;
	logic [PRIORITY_BITS-1:0] bp_q;
	logic [CC-1:0]            ci_q;
	logic                     cfound_q;
	logic [CA-1:0]            cidx_q;
	logic [IB-1:0]            key_q;
	logic                     take_q; // cancel search removes the record
	tpq_pkg::result_t         res_q;
	logic                     rv_q;
	logic [TIME_BITS-1:0]     lt_q;
	logic [IB-1:0]            lid_q;
	logic [PRIORITY_BITS-1:0] lp_q;

	logic [1:0]               c_op;
	logic [TIME_BITS-1:0]     c_tv, c_now;
	logic [PRIORITY_BITS-1:0] c_pv;
	logic [IB-1:0]            c_cid;
	assign {c_cid, c_pv, c_now, c_tv, c_op} = cmd;

	assign cmd_ready = (state_q == S_IDLE) && !rv_q;
	assign res_valid = rv_q;
	assign res       = res_q;

	logic [QA-1:0] ii;
	logic [CA-1:0] cii;
	assign ii  = i_q[QA-1:0];
	assign cii = ci_q[CA-1:0];

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (cmd_valid && cmd_ready) begin
				op_q  <= c_op;
				dl_q  <= (c_tv > c_now) ? c_now : c_tv;
				pv_q  <= c_pv;
				cid_q <= c_cid;
				if (c_op == tpq_pkg::OP_SCHEDULE && due_cnt_q < QC'(QUEUE_DEPTH)) begin
					due_time_q[due_cnt_q[QA-1:0]]  <= c_tv;
					due_ident_q[due_cnt_q[QA-1:0]] <= next_id_q;
					due_prio_q[due_cnt_q[QA-1:0]]  <= c_pv;
				end
			end
			S_DSCAN: if (i_q == '0 || due_time_q[ii] < bt_q ||
			             (due_time_q[ii] == bt_q && due_ident_q[ii] < bid_q)) begin
				best_q <= ii; bt_q <= due_time_q[ii];
				bid_q <= due_ident_q[ii]; bp_q <= due_prio_q[ii];
			end
			S_LREAD: begin
				lt_q  <= due_time_q[QA'(due_cnt_q - 1'b1)];
				lid_q <= due_ident_q[QA'(due_cnt_q - 1'b1)];
				lp_q  <= due_prio_q[QA'(due_cnt_q - 1'b1)];
			end
			S_DREM: begin
				due_time_q[best_q] <= lt_q; due_ident_q[best_q] <= lid_q;
				due_prio_q[best_q] <= lp_q;
			end
			S_DMOVE: begin
				rdy_ident_q[rdy_cnt_q[QA-1:0]] <= bid_q;
				rdy_prio_q[rdy_cnt_q[QA-1:0]]  <= bp_q;
			end
			S_RSCAN: if (i_q == '0 || rdy_prio_q[ii] > bp_q ||
			             (rdy_prio_q[ii] == bp_q && rdy_ident_q[ii] < bid_q)) begin
				best_q <= ii; bid_q <= rdy_ident_q[ii]; bp_q <= rdy_prio_q[ii];
			end
			S_RLREAD: begin
				lid_q <= rdy_ident_q[QA'(rdy_cnt_q - 1'b1)];
				lp_q  <= rdy_prio_q[QA'(rdy_cnt_q - 1'b1)];
			end
			S_RREM: begin
				rdy_ident_q[best_q] <= lid_q; rdy_prio_q[best_q] <= lp_q;
			end
			S_CSCAN: if (!cfound_q && ci_q < can_cnt_q && can_ident_q[cii] == key_q)
				cidx_q <= cii;
			S_CDEC: if (!cfound_q && op_q == tpq_pkg::OP_CANCEL && !take_q &&
			            can_cnt_q < CC'(CANCEL_DEPTH))
				can_ident_q[can_cnt_q[CA-1:0]] <= key_q;
			S_CREM: begin
				can_ident_q[cidx_q] <= lid_q;
			end
			default: ;
		endcase
		if (state_q == S_CDEC && cfound_q && take_q)
			lid_q <= can_ident_q[CA'(can_cnt_q - 1'b1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; ctx_q <= C_CANCEL_FRONT;
			due_cnt_q <= '0; rdy_cnt_q <= '0; can_cnt_q <= '0; next_id_q <= '0;
			i_q <= '0; ci_q <= '0; cfound_q <= 1'b0; take_q <= 1'b0;
			rv_q <= 1'b0; res_q <= '0; key_q <= '0;
		end else begin
			// result taken: clear it so the next item starts from zero
			if (rv_q && res_ready) begin
				rv_q  <= 1'b0;
				res_q <= '0;
			end
			unique case (state_q)
				S_IDLE: if (cmd_valid && cmd_ready) begin
					unique case (c_op)
						tpq_pkg::OP_SCHEDULE: begin
							if (due_cnt_q >= QC'(QUEUE_DEPTH)) res_q.refused_full <= 1'b1;
							else begin
								res_q.assigned_id <= next_id_q;
								next_id_q <= (next_id_q + 1'b1) & tpq_pkg::IDENT_MASK;
								due_cnt_q <= due_cnt_q + 1'b1;
							end
							state_q <= S_OUT;
						end
						tpq_pkg::OP_CANCEL: begin
							if (due_cnt_q == '0 && rdy_cnt_q == '0) state_q <= S_OUT;
							else if (due_cnt_q == '0) begin
								key_q <= c_cid; take_q <= 1'b0; ctx_q <= C_CANCEL_SET;
								ci_q <= '0; cfound_q <= 1'b0; state_q <= S_CSCAN;
							end else begin
								ctx_q <= C_CANCEL_FRONT; i_q <= '0; state_q <= S_DSCAN;
							end
						end
						tpq_pkg::OP_DISPATCH: begin
							if (due_cnt_q == '0) begin
								if (rdy_cnt_q == '0) state_q <= S_OUT;
								else begin i_q <= '0; state_q <= S_RSCAN; end
							end else begin
								ctx_q <= C_DISP_DUE; i_q <= '0; state_q <= S_DSCAN;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_DSCAN: begin
					if (i_q == due_cnt_q - 1'b1) state_q <= S_DDEC;
					else i_q <= i_q + 1'b1;
				end
				S_DDEC: begin
					unique case (ctx_q)
						C_CANCEL_FRONT: if (bid_q == cid_q) state_q <= S_LREAD;
							else begin
								key_q <= cid_q; take_q <= 1'b0; ctx_q <= C_CANCEL_SET;
								ci_q <= '0; cfound_q <= 1'b0; state_q <= S_CSCAN;
							end
						C_DISP_DUE: if (bt_q > dl_q) begin
								i_q <= '0;
								state_q <= (rdy_cnt_q == '0) ? S_OUT : S_RSCAN;
							end else if (rdy_cnt_q >= QC'(QUEUE_DEPTH)) begin
								res_q.refused_full <= 1'b1; i_q <= '0; state_q <= S_RSCAN;
							end else state_q <= S_DMOVE;
						default: begin // pop cleanup: is this front recorded?
							key_q <= bid_q; take_q <= 1'b1; ci_q <= '0;
							cfound_q <= 1'b0; state_q <= S_CSCAN;
						end
					endcase
				end
				S_DMOVE: begin
					rdy_cnt_q <= rdy_cnt_q + 1'b1; state_q <= S_LREAD;
				end
				S_LREAD: state_q <= S_DREM;
				S_DREM: begin
					due_cnt_q <= due_cnt_q - 1'b1;
					if (due_cnt_q == QC'(1)) begin
						i_q <= '0;
						if (op_q == tpq_pkg::OP_DISPATCH)
							state_q <= (rdy_cnt_q == '0) ? S_OUT : S_RSCAN;
						else state_q <= S_OUT;
					end else begin
						ctx_q <= C_POP_CHECK; i_q <= '0; state_q <= S_DSCAN;
					end
				end
				S_CSCAN: begin
					if (ci_q < can_cnt_q && can_ident_q[cii] == key_q) cfound_q <= 1'b1;
					if (cfound_q || ci_q >= can_cnt_q) state_q <= S_CDEC;
					else ci_q <= ci_q + 1'b1;
				end
				S_CDEC: begin
					if (!take_q) begin
						if (!cfound_q) begin
							if (can_cnt_q >= CC'(CANCEL_DEPTH)) res_q.refused_full <= 1'b1;
							else can_cnt_q <= can_cnt_q + 1'b1;
						end
						state_q <= S_OUT;
					end else if (cfound_q) state_q <= S_CREM;
					else if (ctx_q == C_READY_CHECK) state_q <= S_RDEC;
					else begin
						// pop cleanup ends: resume the caller
						i_q <= '0;
						if (op_q == tpq_pkg::OP_DISPATCH) begin
							ctx_q <= C_DISP_DUE; state_q <= S_DSCAN;
						end else state_q <= S_OUT;
					end
				end
				S_CREM: begin
					can_cnt_q <= can_cnt_q - 1'b1;
					if (ctx_q == C_READY_CHECK) state_q <= S_RLREAD;
					else state_q <= S_LREAD;
				end
				S_RSCAN: begin
					if (i_q == rdy_cnt_q - 1'b1) begin
						ctx_q <= C_READY_CHECK; take_q <= 1'b1;
						ci_q <= '0; cfound_q <= 1'b0; state_q <= S_CSCAN;
					end else i_q <= i_q + 1'b1;
					if (i_q == rdy_cnt_q - 1'b1) key_q <= (i_q == '0 ||
						rdy_prio_q[ii] > bp_q || (rdy_prio_q[ii] == bp_q &&
						rdy_ident_q[ii] < bid_q)) ? rdy_ident_q[ii] : bid_q;
				end
				S_RDEC: begin
					if (bp_q < pv_q) state_q <= S_OUT;
					else begin
						res_q.dispatched <= 1'b1; res_q.dispatched_id <= bid_q;
						res_q.dispatched_priority <= 8'(bp_q);
						state_q <= S_RLREAD;
					end
				end
				S_RLREAD: state_q <= S_RREM;
				S_RREM: begin
					rdy_cnt_q <= rdy_cnt_q - 1'b1;
					i_q <= '0;
					if (res_q.dispatched || rdy_cnt_q == QC'(1)) state_q <= S_OUT;
					else state_q <= S_RSCAN;
				end
				S_OUT: begin
					rv_q <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/timed_priority_task_queue_unit.sv
// channel | dir | handshake        | payload
// s_axis  | in  | tvalid / tready  | op, time_value, current_time, priority_value, cancel_id
// m_axis  | out | tvalid / tready  | assigned_id, dispatched, dispatched_id, prio, refused_full
//
// Flow: one item at a time; a schedule result is registered in S_OUT after
// its transfer. A cancel or dispatch runs a front search over the N stored
// entries, a cancel-set walk over the C records, and further states per entry
// removed or moved between stores.
// Reset: arst_n clears all counts; stores carry no reset.
// Stalls: a two-entry command queue takes transfers while the engine works;
// a held result stops the engine, not the queue.
module timed_priority_task_queue_unit #(
	parameter int QUEUE_DEPTH   = tpq_pkg::QUEUE_DEPTH_DEF,
	parameter int CANCEL_DEPTH  = tpq_pkg::CANCEL_DEPTH_DEF,
	parameter int TIME_BITS     = tpq_pkg::TIME_BITS_DEF,
	parameter int PRIORITY_BITS = tpq_pkg::PRIORITY_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// op[1:0], time_value[33:2], current_time[65:34], priority_value[73:66],
	// cancel_id[104:74], zero fill to 111
	input  logic [111:0]  s_axis_tdata,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// assigned_id[30:0], dispatched[31], dispatched_id[62:32],
	// dispatched_priority[70:63], refused_full[71]
	output logic [71:0]   m_axis_tdata
);
	localparam int CB = 2 + 2*TIME_BITS + PRIORITY_BITS + tpq_pkg::ID_BITS;

	logic [CB-1:0] in_cmd, cmd;
	logic cmd_valid, cmd_ready;
	tpq_pkg::result_t res;

	// times and priorities sized to the configured widths
	assign in_cmd = {s_axis_tdata[104:74], PRIORITY_BITS'(s_axis_tdata[73:66]),
	                 TIME_BITS'(s_axis_tdata[65:34]), TIME_BITS'(s_axis_tdata[33:2]),
	                 s_axis_tdata[1:0]};

	tpq_front #(.TIME_BITS(TIME_BITS), .PRIORITY_BITS(PRIORITY_BITS), .CMD_BITS(CB))
	u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd, .cmd_valid, .cmd_ready, .cmd
	);

	tpq_engine #(.QUEUE_DEPTH(QUEUE_DEPTH), .CANCEL_DEPTH(CANCEL_DEPTH),
	             .TIME_BITS(TIME_BITS), .PRIORITY_BITS(PRIORITY_BITS), .CMD_BITS(CB))
	u_engine (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	assign m_axis_tdata = {res.refused_full, res.dispatched_priority,
	                       res.dispatched_id, res.dispatched, res.assigned_id};

	// a refused item never carries an identifier
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[71] |-> m_axis_tdata[30:0] == '0)
		else $error("refused result carries id");
	// a result that is not dispatched has no dispatch payload
	a_nodisp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[31] |-> m_axis_tdata[70:32] == '0)
		else $error("stray dispatch payload");
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
endmodule
